/* hdl/hll4_register_update_top_assert.svh */
// assertion macros for the register update block
`ifndef HLL4_REGISTER_UPDATE_TOP_ASSERT_SVH
`define HLL4_REGISTER_UPDATE_TOP_ASSERT_SVH

// consequent holds in the cycle of the antecedent
`define HLL4_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hll4 check failed");

// consequent holds in the cycle after the antecedent
`define HLL4_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hll4 check failed");

`endif

/* hdl/hll4_pkg.sv */
package hll4_pkg;

  localparam int MAX_LG_K_DEF    = 12;
  localparam int AUX_ENTRIES_DEF = 32;
  localparam int LG_K_RESET      = 12;
  localparam int MIN_LG_K        = 4;
  localparam int SLOT_W          = 12;
  localparam int RANK_W          = 6;
  localparam int NIB_W           = 4;
  localparam int LG_W            = 4;

  localparam logic [NIB_W-1:0]  MARKER   = 4'hF;
  localparam logic [RANK_W-1:0] VAL_MAX  = 6'd63;
  localparam logic              CMD_UPDATE = 1'b0;
  localparam logic              CMD_READ   = 1'b1;
  localparam logic [2:0]        ADDR_LG_K  = 3'd0;

  typedef struct packed {
    logic              cmd;
    logic [SLOT_W-1:0] slot;
    logic [RANK_W-1:0] rank;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0] slot_value;
    logic              changed;
    logic [RANK_W-1:0] cur_min_out;
    logic              aux_overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_SWEEP_NIB,
    ST_SWEEP_EXC,
    ST_SWEEP_CHK,
    ST_FETCH,
    ST_VALUE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic accept;
    logic look;
    logic sweep_init;
    logic nib_step;
    logic exc_step;
    logic value;
    logic resp;
    logic clr_step;
  } dp_cmd_t;

  typedef struct packed {
    logic need_sweep;
    logic nib_last;
    logic exc_last;
    logic sweep_again;
    logic clr_last;
    logic out_free;
    logic cfg_wr;
  } dp_sts_t;

endpackage

/* hdl/hll4_ram.sv */
module hll4_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/hll4_dp.sv */
module hll4_dp #(
  parameter int MAX_LG_K    = 12,
  parameter int AUX_ENTRIES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hll4_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hll4_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  input  hll4_pkg::dp_cmd_t   ctl,
  output hll4_pkg::dp_sts_t   sts
);
  import hll4_pkg::*;

  localparam int AW      = MAX_LG_K;
  localparam int CW      = MAX_LG_K + 1;
  localparam int DEPTH   = 1 << MAX_LG_K;
  localparam int EW      = (AUX_ENTRIES > 1) ? $clog2(AUX_ENTRIES) : 1;
  localparam int SW      = (MAX_LG_K > SLOT_W) ? MAX_LG_K : SLOT_W;
  localparam int LGK_RST = (MAX_LG_K < LG_K_RESET) ? MAX_LG_K : LG_K_RESET;
  localparam logic [CW-1:0] CLR_LAST = CW'(DEPTH - 1);
  localparam logic [EW-1:0] EXC_LAST = EW'(AUX_ENTRIES - 1);

  logic [LG_W-1:0]   lg_k_r, lg_k_nxt;
  logic              cmd_r, cmd_nxt;
  logic [AW-1:0]     slot_r, slot_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic [RANK_W-1:0] cur_min_r, cur_min_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [EW-1:0]     eidx_r, eidx_nxt;
  logic              changed_r, changed_nxt;
  logic              ovf_r, ovf_nxt;
  logic [RANK_W-1:0] value_r, value_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic [AW-1:0]     exc_slot_r [AUX_ENTRIES];
  logic [AW-1:0]     exc_slot_nxt [AUX_ENTRIES];
  logic [RANK_W-1:0] exc_val_r [AUX_ENTRIES];
  logic [RANK_W-1:0] exc_val_nxt [AUX_ENTRIES];
  logic [AUX_ENTRIES-1:0] exc_vld_r, exc_vld_nxt;

  logic [CW-1:0]      k_cnt, kmask;
  logic [SW-1:0]      slot_in;
  logic [AW-1:0]      slot_in_a;
  logic               cfg_wr;
  logic [LG_W-1:0]    lg_sat;
  logic [NIB_W-1:0]   rnib;
  logic [AUX_ENTRIES-1:0] hit_vec;
  logic               hit_any, free_any;
  logic [EW-1:0]      hit_idx, free_idx, ent_idx;
  logic [6:0]         cm7, rank7, old_val, nm7, ev7, off7;
  logic               do_upd, big, ovf, commit, at_min, need_sweep;
  logic [RANK_W-1:0]  shifted;
  logic [CW-1:0]      count_look, cnt_exc, idm1;
  logic               nib_wr, nib_zero, ex_move, ex_zero;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [NIB_W-1:0]   wdata;

  hll4_ram #(.WIDTH(NIB_W), .DEPTH(DEPTH)) u_nib_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rnib)
  );

  assign k_cnt     = CW'(1) << lg_k_r;
  assign kmask     = k_cnt - CW'(1);
  assign slot_in   = SW'(in_data.slot);
  assign slot_in_a = slot_in[AW-1:0] & kmask[AW-1:0];
  assign cfg_wr    = psel & penable & pwrite & (paddr[2] == ADDR_LG_K[2]);
  assign prdata    = (paddr[2] == ADDR_LG_K[2]) ? 32'(lg_k_r) : 32'd0;

  always_comb begin
    lg_sat = pwdata[LG_W-1:0];
    if (int'(lg_sat) < MIN_LG_K) lg_sat = LG_W'(MIN_LG_K);
    if (int'(lg_sat) > MAX_LG_K) lg_sat = LG_W'(MAX_LG_K);
  end

  // exception store lookup
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = AUX_ENTRIES - 1; i >= 0; i--) begin
      hit_vec[i] = exc_vld_r[i] & (exc_slot_r[i] == slot_r);
      if (hit_vec[i]) hit_idx = EW'(i);
      if (!exc_vld_r[i]) free_idx = EW'(i);
    end
  end
  assign hit_any  = |hit_vec;
  assign free_any = ~&exc_vld_r;
  assign ent_idx  = hit_any ? hit_idx : free_idx;

  // actual value of the held slot
  assign cm7     = {1'b0, cur_min_r};
  assign rank7   = {1'b0, rank_r};
  assign old_val = (rnib != MARKER) ? cm7 + 7'(rnib) :
                   hit_any ? {1'b0, exc_val_r[hit_idx]} : cm7 + 7'(MARKER);

  assign do_upd  = (cmd_r == CMD_UPDATE) && (rank_r > cur_min_r) && (rank7 > old_val);
  assign shifted = rank_r - cur_min_r;
  assign big     = shifted >= RANK_W'(MARKER);
  assign ovf     = do_upd & big & ~hit_any & ~free_any;
  assign commit  = do_upd & ~ovf;
  assign at_min  = old_val == cm7;

  always_comb begin
    count_look = count_r;
    if (commit && at_min && count_r != '0) count_look = count_r - CW'(1);
  end
  assign need_sweep = commit & at_min & (count_look == '0) & (cur_min_r != VAL_MAX);

  // sweep, nibble pass
  assign idm1     = idx_r - CW'(1);
  assign nib_wr   = (idx_r != '0) && (rnib != '0) && (rnib != MARKER);
  assign nib_zero = (idx_r != '0) && (rnib <= NIB_W'(1));

  // sweep, exception pass
  assign nm7     = cm7 + 7'd1;
  assign ev7     = {1'b0, exc_val_r[eidx_r]};
  assign ex_move = exc_vld_r[eidx_r] && (ev7 < nm7 + 7'(MARKER));
  assign off7    = (ev7 > nm7) ? ev7 - nm7 : 7'd0;
  assign ex_zero = ex_move && (off7 == 7'd0);
  assign cnt_exc = cnt_r + CW'(ex_zero);

  always_comb begin
    raddr = slot_r;
    if (ctl.accept) raddr = slot_in_a;
    else if (ctl.nib_step) raddr = idx_r[AW-1:0];
  end

  always_comb begin
    we    = 1'b0;
    waddr = slot_r;
    wdata = '0;
    if (ctl.clr_step) begin
      we    = 1'b1;
      waddr = idx_r[AW-1:0];
    end else if (ctl.nib_step && nib_wr) begin
      we    = 1'b1;
      waddr = idm1[AW-1:0];
      wdata = rnib - NIB_W'(1);
    end else if (ctl.exc_step && ex_move) begin
      we    = 1'b1;
      waddr = exc_slot_r[eidx_r] & kmask[AW-1:0];
      wdata = off7[NIB_W-1:0];
    end else if (ctl.look && commit) begin
      we    = 1'b1;
      wdata = big ? MARKER : shifted[NIB_W-1:0];
    end
  end

  always_comb begin
    lg_k_nxt      = lg_k_r;
    cmd_nxt       = cmd_r;
    slot_nxt      = slot_r;
    rank_nxt      = rank_r;
    cur_min_nxt   = cur_min_r;
    count_nxt     = count_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    eidx_nxt      = eidx_r;
    changed_nxt   = changed_r;
    ovf_nxt       = ovf_r;
    value_nxt     = value_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    exc_slot_nxt  = exc_slot_r;
    exc_val_nxt   = exc_val_r;
    exc_vld_nxt   = exc_vld_r;

    if (ctl.accept) begin
      cmd_nxt  = in_data.cmd;
      slot_nxt = slot_in_a;
      rank_nxt = in_data.rank;
    end
    if (ctl.look) begin
      changed_nxt = commit;
      ovf_nxt     = ovf;
      value_nxt   = commit ? rank_r : old_val[RANK_W-1:0];
      count_nxt   = count_look;
      if (commit && big) begin
        exc_vld_nxt[ent_idx]  = 1'b1;
        exc_slot_nxt[ent_idx] = slot_r;
        exc_val_nxt[ent_idx]  = rank_r;
      end else if (commit && hit_any) begin
        exc_vld_nxt[hit_idx] = 1'b0;
      end
    end
    if (ctl.sweep_init) begin
      idx_nxt  = '0;
      cnt_nxt  = '0;
      eidx_nxt = '0;
    end
    if (ctl.nib_step) begin
      idx_nxt = idx_r + CW'(1);
      cnt_nxt = cnt_r + CW'(nib_zero);
    end
    if (ctl.exc_step) begin
      eidx_nxt = eidx_r + EW'(1);
      cnt_nxt  = cnt_exc;
      if (ex_move) exc_vld_nxt[eidx_r] = 1'b0;
      if (eidx_r == EXC_LAST) begin
        cur_min_nxt = cur_min_r + RANK_W'(1);
        count_nxt   = cnt_exc;
      end
    end
    if (ctl.value) value_nxt = old_val[RANK_W-1:0];
    if (ctl.clr_step) idx_nxt = idx_r + CW'(1);
    if (ctl.resp) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.slot_value   = value_r;
      out_data_nxt.changed      = changed_r;
      out_data_nxt.cur_min_out  = cur_min_r;
      out_data_nxt.aux_overflow = ovf_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_wr) begin
      lg_k_nxt    = lg_sat;
      cur_min_nxt = '0;
      count_nxt   = CW'(1) << lg_sat;
      exc_vld_nxt = '0;
      idx_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_k_r      <= LG_W'(LGK_RST);
      cur_min_r   <= '0;
      count_r     <= CW'(1) << LGK_RST;
      idx_r       <= '0;
      eidx_r      <= '0;
      exc_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      lg_k_r      <= lg_k_nxt;
      cur_min_r   <= cur_min_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      eidx_r      <= eidx_nxt;
      exc_vld_r   <= exc_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    slot_r     <= slot_nxt;
    rank_r     <= rank_nxt;
    cnt_r      <= cnt_nxt;
    changed_r  <= changed_nxt;
    ovf_r      <= ovf_nxt;
    value_r    <= value_nxt;
    out_data_r <= out_data_nxt;
    exc_slot_r <= exc_slot_nxt;
    exc_val_r  <= exc_val_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.need_sweep  = need_sweep;
  assign sts.nib_last    = idx_r == k_cnt;
  assign sts.exc_last    = eidx_r == EXC_LAST;
  assign sts.sweep_again = (count_r == '0) && (cur_min_r != VAL_MAX);
  assign sts.clr_last    = idx_r == CLR_LAST;
  assign sts.out_free    = ~out_valid_r | out_ready;
  assign sts.cfg_wr      = cfg_wr;

endmodule

/* hdl/hll4_ctrl.sv */
module hll4_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hll4_pkg::dp_sts_t sts,
  output hll4_pkg::dp_cmd_t ctl
);
  import hll4_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        state_nxt = sts.need_sweep ? ST_SWEEP_NIB : ST_RESP;
      end
      ST_SWEEP_NIB: begin
        if (sts.nib_last) state_nxt = ST_SWEEP_EXC;
      end
      ST_SWEEP_EXC: begin
        if (sts.exc_last) state_nxt = ST_SWEEP_CHK;
      end
      ST_SWEEP_CHK: begin
        state_nxt = sts.sweep_again ? ST_SWEEP_NIB : ST_FETCH;
      end
      ST_FETCH: begin
        state_nxt = ST_VALUE;
      end
      ST_VALUE: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (sts.cfg_wr) state_nxt = ST_CLEAR;
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        ctl.accept = in_valid;
      end
      ST_LOOK: begin
        ctl.look       = 1'b1;
        ctl.sweep_init = sts.need_sweep;
      end
      ST_SWEEP_NIB: begin
        ctl.nib_step = 1'b1;
      end
      ST_SWEEP_EXC: begin
        ctl.exc_step = 1'b1;
      end
      ST_SWEEP_CHK: begin
        ctl.sweep_init = sts.sweep_again;
      end
      ST_VALUE: begin
        ctl.value = 1'b1;
      end
      ST_RESP: begin
        ctl.resp = sts.out_free;
      end
      ST_CLEAR: begin
        ctl.clr_step = 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/hll4_register_update_top.sv */
// channel   ports                          role
// input     in_valid in_ready in_data      update or read transaction
// result    out_valid out_ready out_data   one result per transaction
// config    psel penable pwrite paddr ...  lg_k register at byte 0
//
// an update or read passes through nibble ram read, lookup and write, result
// a minimum shift adds sweeps (nibble, exception, check), then fetch, value
// reset and every lg_k write run a clearing pass over all 2^MAX_LG_K nibble
// ram entries, with in_ready low throughout
// a waiting result is held in the output register; in_ready rises once loaded
module hll4_register_update_top #(
  parameter int MAX_LG_K    = hll4_pkg::MAX_LG_K_DEF,
  parameter int AUX_ENTRIES = hll4_pkg::AUX_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hll4_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hll4_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import hll4_pkg::*;

  dp_cmd_t ctl;
  dp_sts_t sts;

  assign pready = 1'b1;

  hll4_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  hll4_dp #(
    .MAX_LG_K    (MAX_LG_K),
    .AUX_ENTRIES (AUX_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

/* hdl/hll4_checker.sv */
`include "hll4_register_update_top_assert.svh"

module hll4_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input hll4_pkg::out_item_t out_data,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [2:0]          paddr
);

  `HLL4_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `HLL4_ASSERT_NOW(a_chg_ovf, out_valid, !(out_data.changed && out_data.aux_overflow))
  `HLL4_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `HLL4_ASSERT_NEXT(a_cfg_clear, psel && penable && pwrite && paddr[2] == 1'b0, !in_ready)

endmodule

bind hll4_register_update_top hll4_checker u_hll4_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr)
);
